// ===== rtl/nca_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, widths and codes for the nearest center assignment block.
package nca_pkg;

	localparam int MAX_CENTERS = 256;
	localparam int MAX_LENGTH  = 64;

	localparam int SAMPLE_W  = 16;
	localparam int SLOT_W    = 8;
	localparam int INDEX_W   = 6;
	localparam int COUNT_W   = 9;
	localparam int LENGTH_W  = 7;
	localparam int NEAREST_W = 8;

	localparam int CIDX_W  = (MAX_CENTERS > 1) ? $clog2(MAX_CENTERS) : 1;
	localparam int NUSED_W = CIDX_W + 1;
	localparam int LEN_AW  = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;
	localparam int LEN_W   = LEN_AW + 1;

	localparam int DIFF_W = SAMPLE_W + 1;
	localparam int SQ_W   = 2 * DIFF_W;
	localparam int SUM_W  = 40;
	localparam logic [SUM_W-1:0] SUM_LIMIT = {SUM_W{1'b1}};

	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	localparam logic OP_CENTER = 1'b0;
	localparam logic OP_FRAME  = 1'b1;

	localparam logic REG_CENTER_COUNT  = 1'b0;
	localparam logic REG_VECTOR_LENGTH = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_ACC,
		ST_SCAN,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic              wr_en;
		logic              rd_en;
		logic [LEN_AW-1:0] addr;
		logic              mul_en;
		logic              acc_en;
		logic              clear;
	} cell_ctrl_t;

	typedef struct packed {
		logic [SUM_W-1:0]  sum;
		logic [CIDX_W-1:0] idx;
	} token_t;

endpackage

// ===== rtl/nearest_center_assign.sv =====
`timescale 1ns / 1ps
// Top level: configuration registers, sequencer and the chain of center cells.
//
//  channel   direction  handshake                     payload
//  request   in         start & !busy                 operation, center_slot, element_index, sample
//  result    out        done, one cycle, no stall     nearest_center
//  config    in         APB psel/penable/pwrite       paddr, pwdata, prdata
//
// A center write goes straight into the selected cell's memory. A frame element passes
// memory read, multiply and accumulate in turn. After the element that ends a frame,
// the minimum token walks the cell chain, one cell per cycle, in ST_SCAN; done follows ST_FINISH.
// Reset clears sums, configuration registers and sequencer; center memories hold no reset value.
module nearest_center_assign (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic                          operation,
	input  logic [nca_pkg::SLOT_W-1:0]    center_slot,
	input  logic [nca_pkg::INDEX_W-1:0]   element_index,
	input  logic [nca_pkg::SAMPLE_W-1:0]  sample,
	output logic                          done,
	output logic [nca_pkg::NEAREST_W-1:0] nearest_center,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [nca_pkg::PADDR_W-1:0]   paddr,
	input  logic [nca_pkg::PDATA_W-1:0]   pwdata,
	output logic [nca_pkg::PDATA_W-1:0]   prdata,
	output logic                          pready
);

	logic [nca_pkg::COUNT_W-1:0]   center_count_q;
	logic [nca_pkg::LENGTH_W-1:0]  vector_length_q;
	nca_pkg::state_t               state_q;
	nca_pkg::state_t               state_d;
	logic [nca_pkg::CIDX_W-1:0]    scan_cnt_q;
	logic [nca_pkg::SAMPLE_W-1:0]  sample_s1;
	logic                          last_q;
	logic                          done_q;
	logic [nca_pkg::NEAREST_W-1:0] nearest_q;

	logic [nca_pkg::NUSED_W-1:0] n_used;
	logic [nca_pkg::LEN_W-1:0]   len_eff;
	logic                        accept;
	logic                        in_range;
	logic                        is_last;
	logic                        wr_ok;
	logic                        cfg_wr;
	nca_pkg::cell_ctrl_t         ctrl;

	logic [nca_pkg::MAX_CENTERS-1:0] wr_sel;
	logic [nca_pkg::MAX_CENTERS-1:0] used;
	nca_pkg::token_t                 chain [nca_pkg::MAX_CENTERS+1];

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_count_q  <= nca_pkg::COUNT_W'(1);
			vector_length_q <= nca_pkg::LENGTH_W'(1);
		end else if (cfg_wr) begin
			case (paddr[2])
				nca_pkg::REG_CENTER_COUNT:  center_count_q  <= pwdata[nca_pkg::COUNT_W-1:0];
				nca_pkg::REG_VECTOR_LENGTH: vector_length_q <= pwdata[nca_pkg::LENGTH_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			nca_pkg::REG_CENTER_COUNT:  prdata = nca_pkg::PDATA_W'(center_count_q);
			nca_pkg::REG_VECTOR_LENGTH: prdata = nca_pkg::PDATA_W'(vector_length_q);
			default:                    prdata = '0;
		endcase
	end

	always_comb begin
		if (center_count_q == '0) begin
			n_used = nca_pkg::NUSED_W'(1);
		end else if (32'(center_count_q) > nca_pkg::MAX_CENTERS) begin
			n_used = nca_pkg::NUSED_W'(nca_pkg::MAX_CENTERS);
		end else begin
			n_used = nca_pkg::NUSED_W'(center_count_q);
		end
		if (vector_length_q == '0) begin
			len_eff = nca_pkg::LEN_W'(1);
		end else if (32'(vector_length_q) > nca_pkg::MAX_LENGTH) begin
			len_eff = nca_pkg::LEN_W'(nca_pkg::MAX_LENGTH);
		end else begin
			len_eff = nca_pkg::LEN_W'(vector_length_q);
		end
	end

	assign accept   = start && !busy;
	assign in_range = 32'(element_index) < 32'(len_eff);
	assign is_last  = 32'(element_index) == (32'(len_eff) - 32'd1);
	assign wr_ok    = (32'(center_slot) < nca_pkg::MAX_CENTERS)
		&& (32'(element_index) < nca_pkg::MAX_LENGTH);

	always_comb begin
		state_d = state_q;
		case (state_q)
			nca_pkg::ST_IDLE: begin
				if (accept && (operation == nca_pkg::OP_FRAME) && in_range) begin
					state_d = nca_pkg::ST_MUL;
				end
			end
			nca_pkg::ST_MUL: begin
				state_d = nca_pkg::ST_ACC;
			end
			nca_pkg::ST_ACC: begin
				state_d = last_q ? nca_pkg::ST_SCAN : nca_pkg::ST_IDLE;
			end
			nca_pkg::ST_SCAN: begin
				if (scan_cnt_q == nca_pkg::CIDX_W'(nca_pkg::MAX_CENTERS - 1)) begin
					state_d = nca_pkg::ST_FINISH;
				end
			end
			nca_pkg::ST_FINISH: begin
				state_d = nca_pkg::ST_IDLE;
			end
			default: begin
				state_d = nca_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		busy        = (state_q != nca_pkg::ST_IDLE);
		ctrl.addr   = nca_pkg::LEN_AW'(element_index);
		ctrl.wr_en  = accept && (operation == nca_pkg::OP_CENTER) && wr_ok;
		ctrl.rd_en  = accept && (operation == nca_pkg::OP_FRAME) && in_range;
		ctrl.mul_en = (state_q == nca_pkg::ST_MUL);
		ctrl.acc_en = (state_q == nca_pkg::ST_ACC);
		ctrl.clear  = (state_q == nca_pkg::ST_FINISH);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= nca_pkg::ST_IDLE;
			scan_cnt_q <= '0;
			done_q     <= 1'b0;
		end else begin
			state_q    <= state_d;
			scan_cnt_q <= (state_q == nca_pkg::ST_SCAN) ? scan_cnt_q + 1'b1 : '0;
			done_q     <= (state_q == nca_pkg::ST_FINISH);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sample_s1 <= sample;
			last_q    <= is_last;
		end
		if (state_q == nca_pkg::ST_FINISH) begin
			nearest_q <= nca_pkg::NEAREST_W'(chain[nca_pkg::MAX_CENTERS].idx);
		end
	end

	assign done           = done_q;
	assign nearest_center = nearest_q;

	assign chain[0].sum = nca_pkg::SUM_LIMIT;
	assign chain[0].idx = '0;

	for (genvar j = 0; j < nca_pkg::MAX_CENTERS; j++) begin : g_cell
		assign wr_sel[j] = (32'(center_slot) == j);
		assign used[j]   = (nca_pkg::NUSED_W'(j) < n_used);

		nca_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (ctrl),
			.wr_sel    (wr_sel[j]),
			.used      (used[j]),
			.index     (nca_pkg::CIDX_W'(j)),
			.wr_data   (sample),
			.sample_s1 (sample_s1),
			.token_in  (chain[j]),
			.token_out (chain[j+1])
		);
	end

	a_done_after_finish: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == nca_pkg::ST_FINISH))
		else $error("result strobe without a finished scan");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	a_skip_out_of_range: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (operation == nca_pkg::OP_FRAME) && !in_range) |=> !busy)
		else $error("ignored frame element started work");

	a_mul_then_acc: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == nca_pkg::ST_MUL) |=> (state_q == nca_pkg::ST_ACC))
		else $error("multiply stage not followed by accumulate");

endmodule

// ===== rtl/nca_cell.sv =====
`timescale 1ns / 1ps
// One center cell: element memory, squared distance accumulator, minimum token stage.
module nca_cell (
	input  logic                         clk,
	input  logic                         arst_n,
	input  nca_pkg::cell_ctrl_t          ctrl,
	input  logic                         wr_sel,
	input  logic                         used,
	input  logic [nca_pkg::CIDX_W-1:0]   index,
	input  logic [nca_pkg::SAMPLE_W-1:0] wr_data,
	input  logic [nca_pkg::SAMPLE_W-1:0] sample_s1,
	input  nca_pkg::token_t              token_in,
	output nca_pkg::token_t              token_out
);

	logic [nca_pkg::SAMPLE_W-1:0] mem [nca_pkg::MAX_LENGTH];
	logic [nca_pkg::SAMPLE_W-1:0] rd_q;
	logic [nca_pkg::SQ_W-1:0]     sq_q;
	logic [nca_pkg::SUM_W-1:0]    sum_q;
	nca_pkg::token_t              token_q;

	logic signed [nca_pkg::DIFF_W-1:0] diff;
	logic signed [nca_pkg::SQ_W-1:0]   prod;
	logic [nca_pkg::SUM_W:0]           sum_wide;
	logic [nca_pkg::SUM_W-1:0]         sum_next;

	always_ff @(posedge clk) begin
		if (ctrl.wr_en && wr_sel) begin
			mem[ctrl.addr] <= wr_data;
		end
		if (ctrl.rd_en) begin
			rd_q <= mem[ctrl.addr];
		end
	end

	always_comb begin
		diff = $signed({sample_s1[nca_pkg::SAMPLE_W-1], sample_s1})
			- $signed({rd_q[nca_pkg::SAMPLE_W-1], rd_q});
		prod = diff * diff;
	end

	always_ff @(posedge clk) begin
		if (ctrl.mul_en) begin
			sq_q <= prod;
		end
	end

	always_comb begin
		sum_wide = {1'b0, sum_q} + (nca_pkg::SUM_W + 1)'(sq_q);
		sum_next = sum_wide[nca_pkg::SUM_W] ? nca_pkg::SUM_LIMIT
			: sum_wide[nca_pkg::SUM_W-1:0];
	end

	// clear on finish; accumulate only for a center in use, else hold the sum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (ctrl.clear) begin
			sum_q <= '0;
		end else if (ctrl.acc_en && used) begin
			sum_q <= sum_next;
		end
	end

	// keep the lowest index on ties: take over only on a strictly smaller sum
	always_ff @(posedge clk) begin
		if (used && (sum_q < token_in.sum)) begin
			token_q.sum <= sum_q;
			token_q.idx <= index;
		end else begin
			token_q <= token_in;
		end
	end

	assign token_out = token_q;

endmodule

// ===== tb/tb_nearest_center_assign.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for nearest_center_assign: directed table, center preload, random frames.
module tb_nearest_center_assign;

	localparam int SETTLE     = nca_pkg::MAX_CENTERS + 16;
	localparam int SEG_ITEMS  = 50;
	localparam int DRAIN_LIMIT = 20000;

	typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

	typedef struct packed {
		row_kind_t                       kind;
		logic                            op;
		logic [nca_pkg::SLOT_W-1:0]      slot;
		logic [nca_pkg::INDEX_W-1:0]     idx;
		logic [nca_pkg::SAMPLE_W-1:0]    smp;
		logic                            chk;
		logic [nca_pkg::NEAREST_W-1:0]   nearest;
		logic                            reg_sel;
		logic [nca_pkg::PDATA_W-1:0]     value;
	} plan_row_t;

	logic                           clk;
	logic                           arst_n;
	logic                           start;
	logic                           busy;
	logic                           operation;
	logic [nca_pkg::SLOT_W-1:0]     center_slot;
	logic [nca_pkg::INDEX_W-1:0]    element_index;
	logic [nca_pkg::SAMPLE_W-1:0]   sample;
	logic                           done;
	logic [nca_pkg::NEAREST_W-1:0]  nearest_center;
	logic                           psel;
	logic                           penable;
	logic                           pwrite;
	logic [nca_pkg::PADDR_W-1:0]    paddr;
	logic [nca_pkg::PDATA_W-1:0]    pwdata;
	logic [nca_pkg::PDATA_W-1:0]    prdata;
	logic                           pready;

	logic [nca_pkg::SAMPLE_W-1:0]   center_mem [nca_pkg::MAX_CENTERS][nca_pkg::MAX_LENGTH];
	bit                             written [nca_pkg::MAX_CENTERS][nca_pkg::MAX_LENGTH];
	logic [nca_pkg::SUM_W-1:0]      dist_acc [nca_pkg::MAX_CENTERS];
	logic [nca_pkg::COUNT_W-1:0]    cfg_count;
	logic [nca_pkg::LENGTH_W-1:0]   cfg_len;
	logic [nca_pkg::NEAREST_W-1:0]  nearest_q [$];
	plan_row_t                      plan [$];
	int                             mismatches;
	int                             items_sent;
	int                             idle_pct;
	bit                             start_held;

	nearest_center_assign dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.operation      (operation),
		.center_slot    (center_slot),
		.element_index  (element_index),
		.sample         (sample),
		.done           (done),
		.nearest_center (nearest_center),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	initial begin
		#(64'd48_000_000);
		$display("Mismatches found");
		$finish;
	end

	function automatic int unsigned used_centers();
		if (cfg_count == 0)
			return 1;
		if (cfg_count > nca_pkg::MAX_CENTERS)
			return nca_pkg::MAX_CENTERS;
		return cfg_count;
	endfunction

	function automatic int unsigned used_length();
		if (cfg_len == 0)
			return 1;
		if (cfg_len > nca_pkg::MAX_LENGTH)
			return nca_pkg::MAX_LENGTH;
		return cfg_len;
	endfunction

	function automatic plan_row_t req_row(logic op, logic [nca_pkg::SLOT_W-1:0] slot,
			logic [nca_pkg::INDEX_W-1:0] idx, logic [nca_pkg::SAMPLE_W-1:0] smp, logic chk,
			logic [nca_pkg::NEAREST_W-1:0] nearest);
		plan_row_t r;
		r = '0;
		r.kind    = ROW_REQ;
		r.op      = op;
		r.slot    = slot;
		r.idx     = idx;
		r.smp     = smp;
		r.chk     = chk;
		r.nearest = nearest;
		return r;
	endfunction

	function automatic plan_row_t cfg_row(logic reg_sel, logic [nca_pkg::PDATA_W-1:0] value);
		plan_row_t r;
		r = '0;
		r.kind    = ROW_CFG;
		r.reg_sel = reg_sel;
		r.value   = value;
		return r;
	endfunction

	task automatic note_mismatch(input string what, input longint exp_v, input longint act_v);
		mismatches++;
		if (mismatches <= 10)
			$display("MISMATCH %s: expected %0d, got %0d", what, exp_v, act_v);
	endtask

	task automatic track_request(input logic op, input logic [nca_pkg::SLOT_W-1:0] slot,
			input logic [nca_pkg::INDEX_W-1:0] idx, input logic [nca_pkg::SAMPLE_W-1:0] smp,
			output bit produced, output bit ignored,
			output logic [nca_pkg::NEAREST_W-1:0] pick);
		int unsigned n;
		int unsigned len;
		int unsigned best;
		longint d;
		longint tot;
		logic [nca_pkg::SUM_W-1:0] best_sum;
		produced = 1'b0;
		ignored  = 1'b0;
		pick     = '0;
		n   = used_centers();
		len = used_length();
		if (op == nca_pkg::OP_CENTER) begin
			center_mem[slot][idx] = smp;
			written[slot][idx]    = 1'b1;
		end else if (idx >= len) begin
			ignored = 1'b1;
		end else begin
			for (int j = 0; j < n; j++) begin
				d = longint'($signed(smp)) - longint'($signed(center_mem[j][idx]));
				tot = longint'(dist_acc[j]) + d * d;
				dist_acc[j] = (tot > longint'(nca_pkg::SUM_LIMIT)) ? nca_pkg::SUM_LIMIT
					: tot[nca_pkg::SUM_W-1:0];
			end
			if (idx == len - 1) begin
				best     = 0;
				best_sum = dist_acc[0];
				for (int j = 1; j < n; j++) begin
					if (dist_acc[j] < best_sum) begin
						best_sum = dist_acc[j];
						best     = j;
					end
				end
				for (int j = 0; j < nca_pkg::MAX_CENTERS; j++)
					dist_acc[j] = '0;
				produced = 1'b1;
				pick     = nca_pkg::NEAREST_W'(best);
			end
		end
	endtask

	task automatic send_request(input logic op, input logic [nca_pkg::SLOT_W-1:0] slot,
			input logic [nca_pkg::INDEX_W-1:0] idx, input logic [nca_pkg::SAMPLE_W-1:0] smp,
			input logic chk, input logic [nca_pkg::NEAREST_W-1:0] typed);
		bit produced;
		bit ignored;
		logic [nca_pkg::NEAREST_W-1:0] pick;
		int gap;
		operation     <= op;
		center_slot   <= slot;
		element_index <= idx;
		sample        <= smp;
		start         <= 1'b1;
		start_held = 1'b1;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		track_request(op, slot, idx, smp, produced, ignored, pick);
		if (produced)
			nearest_q.push_back(chk ? typed : pick);
		if (!ignored)
			items_sent++;
		gap = 0;
		while (gap < 24 && $urandom_range(99) < idle_pct)
			gap++;
		if (gap > 0) begin
			start <= 1'b0;
			start_held = 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic hold_start_low();
		if (start_held) begin
			start <= 1'b0;
			start_held = 1'b0;
		end
	endtask

	task automatic drain_requests();
		hold_start_low();
		while (nearest_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input logic reg_sel, input logic [nca_pkg::PDATA_W-1:0] value);
		logic [nca_pkg::PDATA_W-1:0] data;
		logic [nca_pkg::PDATA_W-1:0] mask;
		mask = (reg_sel == nca_pkg::REG_CENTER_COUNT) ? 32'h1FF : 32'h7F;
		data = ($urandom() & ~mask) | (value & mask);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {reg_sel, 2'b00};
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		if (reg_sel == nca_pkg::REG_CENTER_COUNT)
			cfg_count = data[nca_pkg::COUNT_W-1:0];
		else
			cfg_len = data[nca_pkg::LENGTH_W-1:0];
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	// write every center entry the current setting can read and that is still empty
	task automatic fill_needed();
		int unsigned n;
		int unsigned len;
		n   = used_centers();
		len = used_length();
		for (int s = 0; s < n; s++)
			for (int p = 0; p < len; p++)
				if (!written[s][p])
					send_request(nca_pkg::OP_CENTER, nca_pkg::SLOT_W'(s),
						nca_pkg::INDEX_W'(p), nca_pkg::SAMPLE_W'($urandom()), 1'b0, '0);
	endtask

	task automatic frame_near(input int unsigned target, input int mode);
		int unsigned len;
		logic [nca_pkg::SAMPLE_W-1:0] smp;
		len = used_length();
		for (int p = 0; p < len; p++) begin
			case (mode)
				0: smp = center_mem[target][p];
				1: smp = center_mem[target][p] + nca_pkg::SAMPLE_W'($urandom_range(0, 511))
					- 16'd256;
				default: smp = nca_pkg::SAMPLE_W'($urandom());
			endcase
			send_request(nca_pkg::OP_FRAME, nca_pkg::SLOT_W'($urandom()),
				nca_pkg::INDEX_W'(p), smp, 1'b0, '0);
		end
	endtask

	task automatic random_center_write();
		send_request(nca_pkg::OP_CENTER, nca_pkg::SLOT_W'($urandom()),
			nca_pkg::INDEX_W'($urandom()), nca_pkg::SAMPLE_W'($urandom()), 1'b0, '0);
	endtask

	task automatic run_sequence();
		int unsigned n;
		int unsigned len;
		int unsigned a;
		int unsigned b;
		int r;
		n   = used_centers();
		len = used_length();
		r   = $urandom_range(99);
		if (r < 58) begin
			frame_near($urandom_range(0, n - 1), $urandom_range(0, 2));
		end else if (r < 68) begin
			repeat ($urandom_range(1, 4)) random_center_write();
		end else if (r < 76) begin
			a = $urandom_range(0, n - 1);
			b = $urandom_range(0, n - 1);
			for (int p = 0; p < len; p++)
				send_request(nca_pkg::OP_CENTER, nca_pkg::SLOT_W'(b), nca_pkg::INDEX_W'(p),
					center_mem[a][p], 1'b0, '0);
			frame_near(a, 0);
		end else if (r < 90) begin
			repeat ($urandom_range(1, 2 * len)) begin
				if ($urandom_range(99) < 20)
					random_center_write();
				else
					send_request(nca_pkg::OP_FRAME, nca_pkg::SLOT_W'($urandom()),
						nca_pkg::INDEX_W'($urandom_range(0, len - 1)),
						nca_pkg::SAMPLE_W'($urandom()), 1'b0, '0);
			end
		end else if (len < nca_pkg::MAX_LENGTH) begin
			repeat ($urandom_range(1, 3))
				send_request(nca_pkg::OP_FRAME, nca_pkg::SLOT_W'($urandom()),
					nca_pkg::INDEX_W'($urandom_range(len, nca_pkg::MAX_LENGTH - 1)),
					nca_pkg::SAMPLE_W'($urandom()), 1'b0, '0);
		end else begin
			random_center_write();
		end
	endtask

	task automatic pick_setting(input int k);
		logic [nca_pkg::PDATA_W-1:0] cc;
		logic [nca_pkg::PDATA_W-1:0] vl;
		case (k % 8)
			0: begin cc = 1; vl = 1; end
			1: begin cc = nca_pkg::MAX_CENTERS; vl = 1; end
			2: begin cc = $urandom_range(2, 8); vl = $urandom_range(2, 8); end
			3: begin cc = 0; vl = 127; end
			4: begin cc = 511; vl = 0; end
			5: begin cc = $urandom_range(2, 3); vl = nca_pkg::MAX_LENGTH; end
			6: begin cc = $urandom_range(257, 511); vl = 1; end
			default: begin cc = $urandom_range(1, 16); vl = $urandom_range(1, 8); end
		endcase
		drain_requests();
		write_reg(nca_pkg::REG_CENTER_COUNT, cc);
		write_reg(nca_pkg::REG_VECTOR_LENGTH, vl);
		fill_needed();
	endtask

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (nearest_q.size() == 0)
				note_mismatch("unexpected result", -1, nearest_center);
			else if (nearest_center !== nearest_q[0]) begin
				note_mismatch("nearest_center", nearest_q[0], nearest_center);
				void'(nearest_q.pop_front());
			end else
				void'(nearest_q.pop_front());
		end
	end

	initial begin
		int seg;
		int seg_start;
		int waited;
		arst_n        = 1'b0;
		start         = 1'b0;
		operation     = nca_pkg::OP_CENTER;
		center_slot   = '0;
		element_index = '0;
		sample        = '0;
		psel          = 1'b0;
		penable       = 1'b0;
		pwrite        = 1'b0;
		paddr         = '0;
		pwdata        = '0;
		mismatches    = 0;
		items_sent    = 0;
		idle_pct      = 0;
		start_held    = 1'b0;
		cfg_count     = 1;
		cfg_len       = 1;
		for (int s = 0; s < nca_pkg::MAX_CENTERS; s++) begin
			dist_acc[s] = '0;
			for (int p = 0; p < nca_pkg::MAX_LENGTH; p++) begin
				center_mem[s][p] = '0;
				written[s][p]    = 1'b0;
			end
		end

		plan.push_back(req_row(nca_pkg::OP_CENTER, 8'd0, 6'd0, 16'h8000, 1'b0, 8'd0));
		plan.push_back(req_row(nca_pkg::OP_FRAME, 8'd0, 6'd0, 16'h7FFF, 1'b1, 8'd0));
		plan.push_back(req_row(nca_pkg::OP_FRAME, 8'hFF, 6'd1, 16'h0000, 1'b0, 8'd0));
		plan.push_back(req_row(nca_pkg::OP_FRAME, 8'h5A, 6'd63, 16'h1234, 1'b0, 8'd0));
		plan.push_back(req_row(nca_pkg::OP_CENTER, 8'd255, 6'd63, 16'h7FFF, 1'b0, 8'd0));
		plan.push_back(cfg_row(nca_pkg::REG_CENTER_COUNT, 32'd0));
		plan.push_back(cfg_row(nca_pkg::REG_VECTOR_LENGTH, 32'd0));
		plan.push_back(req_row(nca_pkg::OP_FRAME, 8'd0, 6'd0, 16'h0000, 1'b1, 8'd0));
		plan.push_back(cfg_row(nca_pkg::REG_CENTER_COUNT, 32'd3));
		plan.push_back(cfg_row(nca_pkg::REG_VECTOR_LENGTH, 32'd2));
		plan.push_back(req_row(nca_pkg::OP_CENTER, 8'd0, 6'd1, 16'h0100, 1'b0, 8'd0));
		plan.push_back(req_row(nca_pkg::OP_CENTER, 8'd1, 6'd0, 16'h0200, 1'b0, 8'd0));
		plan.push_back(req_row(nca_pkg::OP_CENTER, 8'd1, 6'd1, 16'h0300, 1'b0, 8'd0));
		plan.push_back(req_row(nca_pkg::OP_CENTER, 8'd2, 6'd0, 16'h0200, 1'b0, 8'd0));
		plan.push_back(req_row(nca_pkg::OP_CENTER, 8'd2, 6'd1, 16'h0300, 1'b0, 8'd0));
		// tie between two identical centers: lower index wins
		plan.push_back(req_row(nca_pkg::OP_FRAME, 8'd7, 6'd0, 16'h0200, 1'b0, 8'd0));
		plan.push_back(req_row(nca_pkg::OP_FRAME, 8'd7, 6'd1, 16'h0300, 1'b1, 8'd1));
		// repeated position within a frame
		plan.push_back(req_row(nca_pkg::OP_FRAME, 8'd0, 6'd0, 16'h8000, 1'b0, 8'd0));
		plan.push_back(req_row(nca_pkg::OP_FRAME, 8'd0, 6'd0, 16'h8000, 1'b0, 8'd0));
		plan.push_back(req_row(nca_pkg::OP_FRAME, 8'd0, 6'd1, 16'h0100, 1'b1, 8'd0));
		// skipped position: only the last element is summed
		plan.push_back(req_row(nca_pkg::OP_FRAME, 8'd3, 6'd1, 16'h0300, 1'b1, 8'd1));

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			if (plan[i].kind == ROW_CFG) begin
				drain_requests();
				write_reg(plan[i].reg_sel, plan[i].value);
			end else begin
				send_request(plan[i].op, plan[i].slot, plan[i].idx, plan[i].smp,
					plan[i].chk, plan[i].nearest);
			end
		end

		seg = 0;
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				1: idle_pct = 58;
				3: idle_pct = 33;
				default: idle_pct = 0;
			endcase
			repeat (4) begin
				pick_setting(seg);
				seg++;
				seg_start = items_sent;
				while (items_sent - seg_start < SEG_ITEMS)
					run_sequence();
			end
			if (phase == 0) begin
				// drive the sums into saturation by repeating one position
				drain_requests();
				write_reg(nca_pkg::REG_CENTER_COUNT, 32'd3);
				write_reg(nca_pkg::REG_VECTOR_LENGTH, 32'd2);
				fill_needed();
				send_request(nca_pkg::OP_CENTER, 8'd0, 6'd0, 16'h8000, 1'b0, '0);
				send_request(nca_pkg::OP_CENTER, 8'd1, 6'd0, 16'h8000, 1'b0, '0);
				send_request(nca_pkg::OP_CENTER, 8'd2, 6'd0, 16'h8001, 1'b0, '0);
				repeat (260)
					send_request(nca_pkg::OP_FRAME, nca_pkg::SLOT_W'($urandom()), 6'd0,
						16'h7FFF, 1'b0, '0);
				send_request(nca_pkg::OP_FRAME, nca_pkg::SLOT_W'($urandom()), 6'd1,
					nca_pkg::SAMPLE_W'($urandom()), 1'b0, '0);
			end
		end

		hold_start_low();
		waited = 0;
		while (nearest_q.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (SETTLE) @(posedge clk);
		if (nearest_q.size() != 0)
			note_mismatch("results never delivered", 0, nearest_q.size());

		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
